@@ hw/rtl/bfha_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit heap allocator package
// Shared widths, operation and status codes, and size rounding.
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int      DEF_MAX_SEGMENTS = 64;
    localparam int      DEF_HEADER_BYTES = 32;
    localparam longint  DEF_HEAP_BYTES   = 64'd1048576;

    localparam int FIELD_W = 21;
    localparam int SIZE_W  = 22;
    localparam int START_W = 20;
    localparam int LIM_W   = 33;

    localparam logic [FIELD_W-1:0] LIMIT_RESET = 21'h100000;

    localparam logic REG_HEAP_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESIZE  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADADDR = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    function automatic logic [SIZE_W-1:0] align8(input logic [FIELD_W-1:0] n);
        logic [SIZE_W-1:0] sum;
        sum = {1'b0, n} + SIZE_W'(7);
        return {sum[SIZE_W-1:3], 3'b000};
    endfunction

endpackage

@@ hw/rtl/bfha_seg_ram.sv @@
// ----------------------------------------------------------------------------
// Segment record memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfha_seg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bfha_slot_pick.sv @@
// ----------------------------------------------------------------------------
// Free slot picker
// Return the lowest slot whose valid bit is clear, or DEPTH when full.
// ----------------------------------------------------------------------------
module bfha_slot_pick #(
    parameter int DEPTH = 64,
    parameter int IW    = 7
) (
    input  logic [DEPTH-1:0] valid,
    output logic [IW-1:0]    slot
);

    always_comb
    begin
        slot = IW'(DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                slot = IW'(i);
            end
        end
    end

endmodule

@@ hw/rtl/best_fit_heap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Best-fit heap allocator core
// Address-ordered segment chain with best-fit search, split and coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present operation, request_bytes and block_address with
//   start high; the command transfers at a clock edge where busy is low.
//   Result channel: done pulses for one cycle with result_address,
//   granted_bytes and status; the receiver cannot stall it.
//   Search: an item walks the segment chain one record per cycle through
//   the segment memory read port; a resize that grows searches first, then
//   releases the old block with merges.
//   A new command may transfer in the cycle done is high.
//   Configuration: APB write of heap_limit_bytes at byte address 0, only
//   while idle.
//   Reset: chain empty, heap top 0, limit at 1 MiB. The segment memory is
//   not cleared; valid bits in flip-flops track which slots are in use.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_core #(
    parameter int     MAX_SEGMENTS = bfha_pkg::DEF_MAX_SEGMENTS,
    parameter int     HEADER_BYTES = bfha_pkg::DEF_HEADER_BYTES,
    parameter longint HEAP_BYTES   = bfha_pkg::DEF_HEAP_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [bfha_pkg::FIELD_W-1:0]  request_bytes,
    input  logic [bfha_pkg::FIELD_W-1:0]  block_address,
    output logic                          done,
    output logic [bfha_pkg::FIELD_W-1:0]  result_address,
    output logic [bfha_pkg::FIELD_W-1:0]  granted_bytes,
    output logic [1:0]                    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import bfha_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int IW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [IW-1:0]     NONE     = IW'(MAX_SEGMENTS);
    localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);
    localparam logic [LIM_W-1:0]  HEAP_CAP = LIM_W'(HEAP_BYTES);

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [FIELD_W-1:0] size;
        logic               free;
        logic [IW-1:0]      next;
        logic [IW-1:0]      prev;
    } seg_t;

    localparam int REC_W = $bits(seg_t);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_DISP   = 17'h00002,
        S_WSTART = 17'h00004,
        S_WALK   = 17'h00008,
        S_WEND   = 17'h00010,
        S_GROW   = 17'h00020,
        S_GTAIL  = 17'h00040,
        S_SPLIT  = 17'h00080,
        S_SNEXT  = 17'h00100,
        S_R0     = 17'h00200,
        S_R1     = 17'h00400,
        S_R2     = 17'h00800,
        S_R3     = 17'h01000,
        S_R4     = 17'h02000,
        S_R5     = 17'h04000,
        S_WR     = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    function automatic logic ok(input logic [IW-1:0] x);
        return x < NONE;
    endfunction

    state_t                  state_reg;
    op_t                     op_reg;
    logic [SIZE_W-1:0]       sz_reg;
    logic [FIELD_W-1:0]      addr_reg;
    logic                    find_mode_reg;
    logic                    grow_reg;
    logic                    found_reg;
    logic                    merged_reg;
    logic                    ret_rel_reg;
    logic                    wb_reg;
    logic                    ws_reg;
    logic [IW-1:0]           cur_reg;
    logic [IW-1:0]           best_reg;
    seg_t                    best_rec_reg;
    seg_t                    rec_a_reg;
    seg_t                    rec_b_reg;
    seg_t                    rec_s_reg;
    logic [IW-1:0]           idx_a_reg;
    logic [IW-1:0]           idx_b_reg;
    logic [IW-1:0]           idx_s_reg;
    logic [IW-1:0]           rel_idx_reg;
    logic [MAX_SEGMENTS-1:0] valid_reg;
    logic [IW-1:0]           head_reg;
    logic [IW-1:0]           tail_reg;
    logic [FIELD_W-1:0]      top_reg;
    logic [FIELD_W-1:0]      limit_reg;
    logic                    done_reg;
    logic [FIELD_W-1:0]      res_addr_reg;
    logic [FIELD_W-1:0]      res_gb_reg;
    status_t                 res_st_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [REC_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    seg_t             wr_rec;
    seg_t             rd_rec;
    logic [IW-1:0]    free_slot;

    logic             hit;
    logic             better;
    logic             do_split;
    logic             grow_fail;
    logic [LIM_W-1:0] lim_c;
    logic [LIM_W-1:0] need_c;
    logic             cfg_wr;

    assign rd_rec = seg_t'(rd_data);

    bfha_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (REC_W),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfha_slot_pick #(
        .DEPTH (MAX_SEGMENTS),
        .IW    (IW)
    ) u_pick (
        .valid (valid_reg),
        .slot  (free_slot)
    );

    assign hit = ({1'b0, rd_rec.start} + SIZE_W'(HEADER_BYTES)) == {1'b0, addr_reg};
    assign better = rd_rec.free && ({1'b0, rd_rec.size} >= sz_reg)
                    && (!ok(best_reg) || (rd_rec.size < best_rec_reg.size));
    assign do_split = ({1'b0, rec_a_reg.size} > (sz_reg + HDR)) && ok(free_slot);
    assign lim_c = (HEAP_CAP < LIM_W'(limit_reg)) ? HEAP_CAP : LIM_W'(limit_reg);
    assign need_c = LIM_W'(top_reg) + LIM_W'(HDR) + LIM_W'(sz_reg);
    assign grow_fail = !ok(free_slot) || (need_c > lim_c);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_rec  = rec_a_reg;
        unique case (state_reg)
            S_WSTART:
            begin
                rd_en   = ok(head_reg);
                rd_addr = head_reg[AW-1:0];
            end
            S_WALK:
            begin
                rd_en   = !(find_mode_reg && hit) && ok(rd_rec.next);
                rd_addr = rd_rec.next[AW-1:0];
            end
            S_GROW:
            begin
                rd_en   = !grow_fail && ok(tail_reg);
                rd_addr = tail_reg[AW-1:0];
            end
            S_SPLIT:
            begin
                rd_en   = do_split && ok(rec_a_reg.next);
                rd_addr = rec_a_reg.next[AW-1:0];
            end
            S_R0:
            begin
                rd_en   = 1'b1;
                rd_addr = rel_idx_reg[AW-1:0];
            end
            S_R1:
            begin
                rd_en   = ok(rd_rec.prev);
                rd_addr = rd_rec.prev[AW-1:0];
            end
            S_R3:
            begin
                rd_en   = ok(rec_a_reg.next);
                rd_addr = rec_a_reg.next[AW-1:0];
            end
            S_R4:
            begin
                rd_en   = rd_rec.free && ok(rd_rec.next);
                rd_addr = rd_rec.next[AW-1:0];
            end
            S_WR:
            begin
                wr_en = 1'b1;
                priority if (wb_reg)
                begin
                    wr_addr = idx_b_reg[AW-1:0];
                    wr_rec  = rec_b_reg;
                end
                else if (ws_reg)
                begin
                    wr_addr = idx_s_reg[AW-1:0];
                    wr_rec  = rec_s_reg;
                end
                else
                begin
                    wr_addr = idx_a_reg[AW-1:0];
                    wr_rec  = rec_a_reg;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            head_reg    <= NONE;
            tail_reg    <= NONE;
            top_reg     <= '0;
            limit_reg   <= LIMIT_RESET;
            done_reg    <= 1'b0;
            wb_reg      <= 1'b0;
            ws_reg      <= 1'b0;
            ret_rel_reg <= 1'b0;
            res_st_reg  <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr && (paddr[2] == REG_HEAP_LIMIT))
            begin
                limit_reg <= pwdata[FIELD_W-1:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= op_t'(operation);
                        sz_reg       <= align8(request_bytes);
                        addr_reg     <= block_address;
                        res_addr_reg <= '0;
                        res_gb_reg   <= '0;
                        res_st_reg   <= ST_OK;
                        grow_reg     <= 1'b0;
                        ret_rel_reg  <= 1'b0;
                        wb_reg       <= 1'b0;
                        ws_reg       <= 1'b0;
                        state_reg    <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    if ((op_reg == OP_ALLOC) || ((op_reg == OP_RESIZE) && (addr_reg == '0)))
                    begin
                        find_mode_reg <= 1'b0;
                        if (sz_reg == '0)
                        begin
                            res_st_reg <= ST_EMPTY;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_WSTART;
                        end
                    end
                    else if (op_reg == OP_RELEASE)
                    begin
                        find_mode_reg <= 1'b1;
                        state_reg     <= (addr_reg == '0) ? S_DONE : S_WSTART;
                    end
                    else if (op_reg == OP_RESIZE)
                    begin
                        find_mode_reg <= 1'b1;
                        state_reg     <= S_WSTART;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_WSTART:
                begin
                    best_reg  <= NONE;
                    found_reg <= 1'b0;
                    cur_reg   <= head_reg;
                    state_reg <= ok(head_reg) ? S_WALK : S_WEND;
                end
                S_WALK:
                begin
                    if (find_mode_reg && hit)
                    begin
                        rec_a_reg <= rd_rec;
                        idx_a_reg <= cur_reg;
                        found_reg <= !rd_rec.free;
                        state_reg <= S_WEND;
                    end
                    else
                    begin
                        if (!find_mode_reg && better)
                        begin
                            best_reg     <= cur_reg;
                            best_rec_reg <= rd_rec;
                        end
                        if (ok(rd_rec.next))
                        begin
                            cur_reg <= rd_rec.next;
                        end
                        else
                        begin
                            state_reg <= S_WEND;
                        end
                    end
                end
                S_WEND:
                begin
                    if (find_mode_reg)
                    begin
                        rel_idx_reg <= idx_a_reg;
                        if (!found_reg)
                        begin
                            res_st_reg <= ST_BADADDR;
                            state_reg  <= S_DONE;
                        end
                        else if ((op_reg == OP_RELEASE) || (sz_reg == '0))
                        begin
                            state_reg <= S_R0;
                        end
                        else if ({1'b0, rec_a_reg.size} < sz_reg)
                        begin
                            grow_reg      <= 1'b1;
                            find_mode_reg <= 1'b0;
                            state_reg     <= S_WSTART;
                        end
                        else
                        begin
                            state_reg <= S_SPLIT;
                        end
                    end
                    else if (ok(best_reg))
                    begin
                        rec_a_reg <= {best_rec_reg.start, best_rec_reg.size, 1'b0,
                                      best_rec_reg.next, best_rec_reg.prev};
                        idx_a_reg <= best_reg;
                        state_reg <= S_SPLIT;
                    end
                    else
                    begin
                        state_reg <= S_GROW;
                    end
                end
                S_GROW:
                begin
                    if (grow_fail)
                    begin
                        res_st_reg <= ST_NOSPACE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        rec_a_reg <= {top_reg[START_W-1:0], sz_reg[FIELD_W-1:0], 1'b0,
                                      NONE, tail_reg};
                        idx_a_reg <= free_slot;
                        idx_b_reg <= tail_reg;
                        valid_reg[free_slot[AW-1:0]] <= 1'b1;
                        if (!ok(head_reg))
                        begin
                            head_reg <= free_slot;
                        end
                        tail_reg     <= free_slot;
                        top_reg      <= need_c[FIELD_W-1:0];
                        res_addr_reg <= FIELD_W'({1'b0, top_reg} + HDR);
                        res_gb_reg   <= sz_reg[FIELD_W-1:0];
                        ret_rel_reg  <= grow_reg;
                        state_reg    <= ok(tail_reg) ? S_GTAIL : S_WR;
                    end
                end
                S_GTAIL:
                begin
                    rec_b_reg <= {rd_rec.start, rd_rec.size, rd_rec.free,
                                  idx_a_reg, rd_rec.prev};
                    wb_reg    <= 1'b1;
                    state_reg <= S_WR;
                end
                S_SPLIT:
                begin
                    res_addr_reg <= FIELD_W'({1'b0, rec_a_reg.start} + HDR);
                    ret_rel_reg  <= grow_reg;
                    if (do_split)
                    begin
                        rec_s_reg <= {START_W'({1'b0, rec_a_reg.start} + HDR + sz_reg),
                                      FIELD_W'({1'b0, rec_a_reg.size} - sz_reg - HDR),
                                      1'b1, rec_a_reg.next, idx_a_reg};
                        idx_s_reg <= free_slot;
                        idx_b_reg <= rec_a_reg.next;
                        ws_reg    <= 1'b1;
                        valid_reg[free_slot[AW-1:0]] <= 1'b1;
                        rec_a_reg <= {rec_a_reg.start, sz_reg[FIELD_W-1:0], rec_a_reg.free,
                                      free_slot, rec_a_reg.prev};
                        res_gb_reg <= sz_reg[FIELD_W-1:0];
                        if (ok(rec_a_reg.next))
                        begin
                            state_reg <= S_SNEXT;
                        end
                        else
                        begin
                            tail_reg  <= free_slot;
                            state_reg <= S_WR;
                        end
                    end
                    else
                    begin
                        res_gb_reg <= rec_a_reg.size;
                        state_reg  <= S_WR;
                    end
                end
                S_SNEXT:
                begin
                    rec_b_reg <= {rd_rec.start, rd_rec.size, rd_rec.free,
                                  rd_rec.next, idx_s_reg};
                    wb_reg    <= 1'b1;
                    state_reg <= S_WR;
                end
                S_R0:
                begin
                    state_reg <= S_R1;
                end
                S_R1:
                begin
                    rec_a_reg  <= {rd_rec.start, rd_rec.size, 1'b1, rd_rec.next, rd_rec.prev};
                    idx_a_reg  <= rel_idx_reg;
                    merged_reg <= 1'b0;
                    state_reg  <= ok(rd_rec.prev) ? S_R2 : S_R3;
                end
                S_R2:
                begin
                    if (rd_rec.free)
                    begin
                        rec_a_reg <= {rd_rec.start,
                                      FIELD_W'({1'b0, rec_a_reg.size}
                                               + {1'b0, rd_rec.size} + HDR),
                                      rd_rec.free, rec_a_reg.next, rd_rec.prev};
                        idx_a_reg  <= rec_a_reg.prev;
                        valid_reg[idx_a_reg[AW-1:0]] <= 1'b0;
                        merged_reg <= 1'b1;
                        if (!ok(rec_a_reg.next))
                        begin
                            tail_reg <= rec_a_reg.prev;
                        end
                    end
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    state_reg <= ok(rec_a_reg.next) ? S_R4 : S_WR;
                end
                S_R4:
                begin
                    if (rd_rec.free)
                    begin
                        rec_a_reg <= {rec_a_reg.start,
                                      FIELD_W'({1'b0, rec_a_reg.size}
                                               + {1'b0, rd_rec.size} + HDR),
                                      rec_a_reg.free, rd_rec.next, rec_a_reg.prev};
                        valid_reg[rec_a_reg.next[AW-1:0]] <= 1'b0;
                        if (ok(rd_rec.next))
                        begin
                            state_reg <= S_R5;
                        end
                        else
                        begin
                            tail_reg  <= idx_a_reg;
                            state_reg <= S_WR;
                        end
                    end
                    else
                    begin
                        if (merged_reg)
                        begin
                            rec_b_reg <= {rd_rec.start, rd_rec.size, rd_rec.free,
                                          rd_rec.next, idx_a_reg};
                            idx_b_reg <= rec_a_reg.next;
                            wb_reg    <= 1'b1;
                        end
                        state_reg <= S_WR;
                    end
                end
                S_R5:
                begin
                    rec_b_reg <= {rd_rec.start, rd_rec.size, rd_rec.free,
                                  rd_rec.next, idx_a_reg};
                    idx_b_reg <= rec_a_reg.next;
                    wb_reg    <= 1'b1;
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    priority if (wb_reg)
                    begin
                        wb_reg <= 1'b0;
                    end
                    else if (ws_reg)
                    begin
                        ws_reg <= 1'b0;
                    end
                    else if (ret_rel_reg)
                    begin
                        ret_rel_reg <= 1'b0;
                        state_reg   <= S_R0;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign result_address = res_addr_reg;
    assign granted_bytes  = res_gb_reg;
    assign status         = res_st_reg;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == REG_HEAP_LIMIT) ? {11'b0, limit_reg} : 32'b0;

`ifndef SYNTHESIS
    a_done_from_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_DONE))
        else $error("result strobe without finishing state");

    a_head_tail_agree: assert property (@(posedge clk) disable iff (!rst_n)
        ok(head_reg) == ok(tail_reg))
        else $error("chain head and tail disagree on empty chain");

    a_main_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && !wb_reg && !ws_reg) |-> valid_reg[idx_a_reg[AW-1:0]])
        else $error("segment record written to a slot not in use");
`endif

endmodule

@@ tb/sv/best_fit_heap_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// Best-fit heap allocator core testbench
// Drives allocate, release, resize and no-op commands and heap limit writes
// against a behavioural copy of the segment chain and checks every result.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfha_pkg::*;

    localparam int NSEG  = 64;
    localparam int HDR   = 32;
    localparam int HEAPB = 1048576;
    localparam int NIL   = NSEG;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          operation = OP_ALLOC;
    logic [FIELD_W-1:0]  request_bytes = '0;
    logic [FIELD_W-1:0]  block_address = '0;
    logic                done;
    logic [FIELD_W-1:0]  result_address;
    logic [FIELD_W-1:0]  granted_bytes;
    logic [1:0]          status;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    best_fit_heap_allocator_core DUT (.*);

    always #10 clk = ~clk;

    typedef struct packed {
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] granted;
        logic [1:0]         st;
    } outcome_t;

    typedef struct {
        op_t               op;
        logic [FIELD_W-1:0] req;
        logic [FIELD_W-1:0] addr;
        bit                 typed;
        outcome_t           want;
    } row_t;

    longint     s_start [NSEG];
    longint     s_size  [NSEG];
    bit         s_free  [NSEG];
    bit         s_valid [NSEG];
    int         s_next  [NSEG];
    int         s_prev  [NSEG];
    int         head, tail;
    longint     top, limit_bytes;

    outcome_t   pending_results[$];
    int         mismatches = 0;
    bit         failed = 0;
    bit         quiet = 0;
    longint     live_addrs[$];

    function automatic int free_slot();
        for (int i = 0; i < NSEG; i++)
            if (!s_valid[i]) return i;
        return NIL;
    endfunction

    function automatic int lookup_used(longint a);
        int i, n;
        i = head;
        n = 0;
        while (i < NSEG && n < NSEG) begin
            if (s_valid[i] && s_start[i] + HDR == a) return s_free[i] ? NIL : i;
            i = s_next[i];
            n++;
        end
        return NIL;
    endfunction

    function automatic void unlink(int i);
        int p, n;
        p = s_prev[i];
        n = s_next[i];
        if (p < NSEG) s_next[p] = n; else head = n;
        if (n < NSEG) s_prev[n] = p; else tail = p;
        s_valid[i] = 0;
    endfunction

    function automatic void carve(int i, longint sz);
        int s, n;
        if (s_size[i] <= sz + HDR) return;
        s = free_slot();
        if (s >= NSEG) return;
        n = s_next[i];
        s_valid[s] = 1;
        s_free[s]  = 1;
        s_start[s] = s_start[i] + HDR + sz;
        s_size[s]  = s_size[i] - sz - HDR;
        s_prev[s]  = i;
        s_next[s]  = n;
        if (n < NSEG) s_prev[n] = s; else tail = s;
        s_next[i] = s;
        s_size[i] = sz;
    endfunction

    function automatic void give_back(int i);
        int p, n;
        s_free[i] = 1;
        p = s_prev[i];
        if (p < NSEG && s_free[p]) begin
            s_size[p] += s_size[i] + HDR;
            unlink(i);
            i = p;
        end
        n = s_next[i];
        if (n < NSEG && s_free[n]) begin
            s_size[i] += s_size[n] + HDR;
            unlink(n);
        end
    endfunction

    function automatic int grant(longint sz, ref longint ra, ref longint gb);
        int i, best, n, s;
        longint lim;
        i = head;
        best = NIL;
        n = 0;
        while (i < NSEG && n < NSEG) begin
            if (s_valid[i] && s_free[i] && s_size[i] >= sz &&
                (best >= NSEG || s_size[i] < s_size[best]))
                best = i;
            i = s_next[i];
            n++;
        end
        if (best < NSEG) begin
            s_free[best] = 0;
            carve(best, sz);
            ra = s_start[best] + HDR;
            gb = s_size[best];
            return ST_OK;
        end
        lim = limit_bytes < HEAPB ? limit_bytes : HEAPB;
        s = free_slot();
        if (s >= NSEG || top + HDR + sz > lim) return ST_NOSPACE;
        s_valid[s] = 1;
        s_free[s]  = 0;
        s_start[s] = top;
        s_size[s]  = sz;
        s_next[s]  = NIL;
        s_prev[s]  = tail;
        if (tail < NSEG) s_next[tail] = s;
        if (head >= NSEG) head = s;
        tail = s;
        top += HDR + sz;
        ra = s_start[s] + HDR;
        gb = sz;
        return ST_OK;
    endfunction

    function automatic longint round8(longint n);
        return ((n + 7) >> 3) << 3;
    endfunction

    function automatic outcome_t predict_heap(op_t op, longint req, longint a);
        longint ra, gb, sz;
        int st, i;
        outcome_t r;
        ra = 0;
        gb = 0;
        st = ST_OK;
        if (op == OP_ALLOC || (op == OP_RESIZE && a == 0)) begin
            if (req == 0) st = ST_EMPTY;
            else st = grant(round8(req), ra, gb);
        end else if (op == OP_RELEASE) begin
            if (a != 0) begin
                i = lookup_used(a);
                if (i < NSEG) give_back(i); else st = ST_BADADDR;
            end
        end else if (op == OP_RESIZE) begin
            i = lookup_used(a);
            if (i >= NSEG) st = ST_BADADDR;
            else if (req == 0) give_back(i);
            else begin
                sz = round8(req);
                if (s_size[i] < sz) begin
                    st = grant(sz, ra, gb);
                    if (st == ST_OK) give_back(i);
                    else begin
                        ra = 0;
                        gb = 0;
                    end
                end else begin
                    carve(i, sz);
                    ra = s_start[i] + HDR;
                    gb = s_size[i];
                end
            end
        end
        r.addr = FIELD_W'(ra);
        r.granted = FIELD_W'(gb);
        r.st = 2'(st);
        return r;
    endfunction

    function automatic outcome_t res(longint a, longint g, status_t s);
        outcome_t r;
        r.addr = FIELD_W'(a);
        r.granted = FIELD_W'(g);
        r.st = s;
        return r;
    endfunction

    always @(posedge clk) begin
        outcome_t got, exp_r;
        if (rst_n && done) begin
            got = '{result_address, granted_bytes, status};
            if (pending_results.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result addr=%0d granted=%0d status=%0d",
                             got.addr, got.granted, got.st);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr=%0d granted=%0d status=%0d, got %0d %0d %0d",
                                 exp_r.addr, exp_r.granted, exp_r.st,
                                 got.addr, got.granted, got.st);
                end
            end
        end
    end

    task automatic issue(op_t op, logic [FIELD_W-1:0] req, logic [FIELD_W-1:0] a,
                         bit typed, outcome_t want);
        outcome_t p;
        if (!quiet && $urandom_range(99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        request_bytes <= req;
        block_address <= a;
        @(posedge clk);
        while (busy) @(posedge clk);
        p = predict_heap(op, req, a);
        if (typed && p !== want) begin
            failed = 1;
            $display("directed row disagrees with prediction for op %0d", op);
        end
        pending_results.push_back(p);
        if (p.st == ST_OK && p.addr != 0) live_addrs.push_back(p.addr);
    endtask

    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * NSEG + 40) @(posedge clk);
    endtask

    task automatic set_limit(logic [FIELD_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_HEAP_LIMIT);
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_bytes = v;
    endtask

    task automatic random_phase(int count, int big_pct);
        op_t op;
        logic [FIELD_W-1:0] req, a;
        int k;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 2);
            k = $urandom_range(99);
            if (k < 45) op = OP_ALLOC;
            else if (k < 75) op = OP_RELEASE;
            else if (k < 97) op = OP_RESIZE;
            else op = OP_NONE;
            if ($urandom_range(99) < big_pct) req = FIELD_W'($urandom_range(0, 2 ** FIELD_W - 1));
            else if ($urandom_range(9) == 0) req = 0;
            else req = FIELD_W'($urandom_range(1, 600));
            if (live_addrs.size() != 0 && $urandom_range(9) < 8)
                a = FIELD_W'(live_addrs[$urandom_range(live_addrs.size() - 1)]);
            else if ($urandom_range(3) == 0) a = 0;
            else a = FIELD_W'($urandom);
            if (op == OP_RELEASE && $urandom_range(3) == 0 && live_addrs.size() != 0)
                a = FIELD_W'(live_addrs[$urandom_range(live_addrs.size() - 1)] + 8);
            issue(op, req, a, 0, '0);
        end
        quiet = 0;
    endtask

    row_t rows[$];

    initial begin
        head = NIL;
        tail = NIL;
        top = 0;
        limit_bytes = LIMIT_RESET;
        for (int i = 0; i < NSEG; i++) s_valid[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{OP_ALLOC,   21'd0,       21'd0,    1, res(0, 0, ST_EMPTY)},
            '{OP_RELEASE, 21'd0,       21'd0,    1, res(0, 0, ST_OK)},
            '{OP_RELEASE, 21'd0,       21'd64,   1, res(0, 0, ST_BADADDR)},
            '{OP_RESIZE,  21'd8,       21'd64,   1, res(0, 0, ST_BADADDR)},
            '{OP_ALLOC,   21'd1,       21'd0,    1, res(32, 8, ST_OK)},
            '{OP_ALLOC,   21'h1FFFFF,  21'd0,    1, res(0, 0, ST_NOSPACE)},
            '{OP_ALLOC,   21'd200,     21'd0,    0, '0},
            '{OP_ALLOC,   21'd16,      21'd0,    0, '0},
            '{OP_ALLOC,   21'd100,     21'd0,    0, '0},
            '{OP_RELEASE, 21'd0,       21'd72,   0, '0},
            '{OP_RELEASE, 21'd0,       21'd72,   1, res(0, 0, ST_BADADDR)},
            '{OP_ALLOC,   21'd8,       21'd0,    0, '0},
            '{OP_RELEASE, 21'd0,       21'd32,   0, '0},
            '{OP_RELEASE, 21'd0,       21'd304,  0, '0},
            '{OP_RESIZE,  21'd40,      21'd0,    0, '0},
            '{OP_RESIZE,  21'd500,     21'd376,  0, '0},
            '{OP_RESIZE,  21'd8,       21'd416,  0, '0},
            '{OP_RESIZE,  21'd0,       21'd416,  0, '0},
            '{OP_RESIZE,  21'h1FFFFF,  21'd32,   0, '0},
            '{OP_NONE,    21'h1FFFFF,  21'h1FFFFF, 0, '0},
            '{OP_ALLOC,   21'h0FFFE0,  21'd0,    0, '0}
        };
        foreach (rows[r])
            issue(rows[r].op, rows[r].req, rows[r].addr, rows[r].typed, rows[r].want);
        drain();

        random_phase(300, 2);
        drain();
        set_limit(21'd0);
        random_phase(60, 2);
        drain();
        set_limit(21'd2048);
        random_phase(200, 1);
        drain();
        set_limit(21'h1FFFFF);
        random_phase(300, 3);
        drain();
        set_limit(LIMIT_RESET);
        random_phase(140, 3);
        drain();

        if (!failed && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bfha_pkg.sv
hw/rtl/bfha_seg_ram.sv
hw/rtl/bfha_slot_pick.sv
hw/rtl/best_fit_heap_allocator_core.sv
tb/sv/best_fit_heap_allocator_core_tb.sv
